>>> hw/rtl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants of the PCX run-length pixel decoder.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int DEF_MAX_WIDTH      = 4096;
  localparam int DEF_MAX_LINE_BYTES = 4096;
  localparam int QUEUE_DEPTH        = 4;

  // input item modes
  localparam logic [1:0] IN_PAL   = 2'd0;
  localparam logic [1:0] IN_BYTE  = 2'd1;
  localparam logic [1:0] IN_START = 2'd2;

  // queued command codes
  localparam logic [1:0] OP_PAL   = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DEPTH  = 2'd0;
  localparam logic [1:0] CFG_LINE   = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  // depth modes
  localparam logic [1:0] DM_MONO    = 2'd0;
  localparam logic [1:0] DM_PLANAR4 = 2'd1;
  localparam logic [1:0] DM_INDEXED = 2'd2;
  localparam logic [1:0] DM_RGB     = 2'd3;

  localparam logic [7:0] RUN_MARK = 8'hC0;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;   // file byte, or palette index
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [5:0] cnt;    // decoded copies of data
  } cmd_t;

endpackage

>>> hw/rtl/prd_channels.sv
// ----------------------------------------------------------------------------
// prd channels
// Valid/ready channels of the decoder: input items, result items, config.
// ----------------------------------------------------------------------------
interface prd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pal_index;
  logic [7:0] pal_red;
  logic [7:0] pal_green;
  logic [7:0] pal_blue;
  logic [7:0] file_byte;
  modport source (output valid, mode, pal_index, pal_red, pal_green, pal_blue, file_byte,
                  input ready);
  modport sink (input valid, mode, pal_index, pal_red, pal_green, pal_blue, file_byte,
                output ready);
endinterface

interface prd_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  pixel_count;
  logic [23:0] pix0;
  logic [23:0] pix1;
  logic [23:0] pix2;
  logic [23:0] pix3;
  logic [23:0] pix4;
  logic [23:0] pix5;
  logic [23:0] pix6;
  logic [23:0] pix7;
  logic        run_last;
  logic        image_done;
  modport source (output valid, pixel_count, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7,
                  run_last, image_done, input ready);
  modport sink (input valid, pixel_count, pix0, pix1, pix2, pix3, pix4, pix5, pix6, pix7,
                run_last, image_done, output ready);
endinterface

interface prd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/prd_ram.sv
// ----------------------------------------------------------------------------
// prd_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/prd_front.sv
// ----------------------------------------------------------------------------
// prd_front
// Take input items, resolve run-length codes and queue decode commands.
// ----------------------------------------------------------------------------
module prd_front (
  input  logic          clk,
  input  logic          rst,
  prd_in_if.sink        data,
  input  logic          q_full,
  output logic          q_push,
  output prd_pkg::cmd_t q_cmd
);

  logic       awaiting_value;
  logic [5:0] run_left;
  logic       take;

  assign data.ready = !q_full;
  assign take       = data.valid && !q_full;

  always_comb begin
    q_cmd.op    = prd_pkg::OP_BYTE;
    q_cmd.data  = data.file_byte;
    q_cmd.red   = data.pal_red;
    q_cmd.green = data.pal_green;
    q_cmd.blue  = data.pal_blue;
    q_cmd.cnt   = 6'd1;
    q_push      = 1'b0;
    case (data.mode)
      prd_pkg::IN_PAL: begin
        q_cmd.op   = prd_pkg::OP_PAL;
        q_cmd.data = data.pal_index;
        q_push     = take;
      end
      prd_pkg::IN_START: begin
        q_cmd.op = prd_pkg::OP_START;
        q_push   = take;
      end
      prd_pkg::IN_BYTE: begin
        if (awaiting_value) begin
          q_cmd.cnt = run_left;
          q_push    = take && (run_left != 6'd0);
        end else begin
          q_push = take && (data.file_byte < prd_pkg::RUN_MARK);
        end
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_value <= 1'b0;
      run_left       <= '0;
    end else if (take) begin
      if (data.mode == prd_pkg::IN_START) begin
        awaiting_value <= 1'b0;
        run_left       <= '0;
      end else if (data.mode == prd_pkg::IN_BYTE) begin
        if (awaiting_value) begin
          awaiting_value <= 1'b0;
          run_left       <= '0;
        end else if (data.file_byte >= prd_pkg::RUN_MARK) begin
          awaiting_value <= 1'b1;
          run_left       <= 6'(data.file_byte - prd_pkg::RUN_MARK);
        end
      end
    end
  end

endmodule

>>> hw/rtl/prd_queue.sv
// ----------------------------------------------------------------------------
// prd_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module prd_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  prd_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          pop_valid,
  output prd_pkg::cmd_t pop_cmd,
  input  logic          pop
);

  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;

  prd_pkg::cmd_t    slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;
  logic             do_pop;

  assign full      = count == (PW + 1)'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_cmd   = slots[rptr];
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW + 1)'(push) - (PW + 1)'(do_pop);
    end
  end

endmodule

>>> hw/rtl/prd_back.sv
// ----------------------------------------------------------------------------
// prd_back
// Decode queued bytes into pixels through the line stores and the palette.
// ----------------------------------------------------------------------------
module prd_back #(
  parameter int MAX_WIDTH      = prd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LINE_BYTES = prd_pkg::DEF_MAX_LINE_BYTES
) (
  input  logic          clk,
  input  logic          rst,
  prd_cfg_if.sink       cfg,
  input  logic          cmd_valid,
  input  prd_pkg::cmd_t cmd,
  output logic          cmd_ready,
  prd_out_if.source     pixels
);

  localparam int BIW  = MAX_LINE_BYTES > 1 ? $clog2(MAX_LINE_BYTES) : 1;
  localparam int XW   = (BIW + 3 > 17 ? BIW + 3 : 17) + 1;
  localparam int IRD  = (MAX_WIDTH + 7) / 8;
  localparam int IRA  = IRD > 1 ? $clog2(IRD) : 1;
  localparam int RGA  = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_PAL   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  // configuration
  logic [1:0]  depth_mode;
  logic [12:0] line_bytes;
  logic [12:0] image_width;
  logic [15:0] image_height;

  // decode position
  logic [BIW-1:0] byte_in_line;
  logic [1:0]     plane_number;
  logic [15:0]    line_number;
  logic           finished;

  logic [2:0]  st;
  logic [7:0]  v;
  logic [5:0]  cnt;
  logic [3:0]  j;
  logic [3:0]  nr;
  logic [3:0]  n;
  logic        emit;
  logic [7:0]  pidx [8];
  logic [23:0] pix [8];

  // held result and output register
  logic        pend_valid;
  logic [3:0]  pend_n;
  logic [23:0] pend_pix [8];
  logic        pend_done;
  logic        ob_valid;
  logic [3:0]  ob_n;
  logic [23:0] ob_pix [8];
  logic        ob_last;
  logic        ob_done;
  logic        ob_load;

  logic [XW-1:0] bx;
  logic [XW-1:0] lbc;
  logic [XW-1:0] wc;
  logic          last_plane;
  logic          line_end;
  logic          img_end;
  logic          ob_free;
  logic          finishing;

  logic [31:0] row;
  logic [31:0] new_row;
  logic        idx_we;
  logic [15:0] rg;
  logic [15:0] rg_wdata;
  logic        rg_we;
  logic        pal_we;
  logic [23:0] pal_rdata;
  logic [7:0]  mod_pidx [8];
  logic [3:0]  mod_n;
  logic        mod_emit;
  logic        b_in;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode   <= prd_pkg::DM_INDEXED;
      line_bytes   <= 13'd1;
      image_width  <= 13'd1;
      image_height <= 16'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        prd_pkg::CFG_DEPTH:  depth_mode   <= cfg.data[1:0];
        prd_pkg::CFG_LINE:   line_bytes   <= cfg.data[12:0];
        prd_pkg::CFG_WIDTH:  image_width  <= cfg.data[12:0];
        prd_pkg::CFG_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  assign bx  = XW'(byte_in_line);
  assign lbc = (line_bytes == 13'd0) ? XW'(1) :
               (XW'(line_bytes) > XW'(MAX_LINE_BYTES) ? XW'(MAX_LINE_BYTES) : XW'(line_bytes));
  assign wc  = (XW'(image_width) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(image_width);
  assign b_in = bx < wc;

  always_comb begin
    case (depth_mode)
      prd_pkg::DM_PLANAR4: last_plane = plane_number == 2'd3;
      prd_pkg::DM_RGB:     last_plane = plane_number >= 2'd2;
      default:             last_plane = 1'b1;
    endcase
  end

  assign line_end  = (bx + XW'(1)) >= lbc;
  assign img_end   = ({1'b0, line_number} + 17'd1) >= {1'b0, image_height};
  assign finishing = line_end && last_plane && img_end;
  assign ob_free   = !ob_valid || pixels.ready;

  // load the output register from the held result
  assign ob_load = pend_valid && ob_free && (((st == S_EMIT) && emit) || (st == S_FLUSH));

  // Line stores and palette
  prd_ram #(.WIDTH(32), .DEPTH(IRD)) u_index_line (
    .clk   (clk),
    .we    (idx_we),
    .waddr (bx[IRA-1:0]),
    .wdata (new_row),
    .raddr (bx[IRA-1:0]),
    .rdata (row)
  );

  prd_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_red_green_line (
    .clk   (clk),
    .we    (rg_we),
    .waddr (bx[RGA-1:0]),
    .wdata (rg_wdata),
    .raddr (bx[RGA-1:0]),
    .rdata (rg)
  );

  assign pal_we = (st == S_IDLE) && cmd_valid && (cmd.op == prd_pkg::OP_PAL);

  prd_ram #(.WIDTH(24), .DEPTH(256)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (cmd.data),
    .wdata ({cmd.red, cmd.green, cmd.blue}),
    .raddr (pidx[j[2:0]]),
    .rdata (pal_rdata)
  );

  // Per-byte pixel work, valid in S_MOD with the line store data back
  always_comb begin
    logic [XW-1:0] x;
    logic          inw;
    logic          bitk;
    logic [3:0]    oldnib;
    logic [3:0]    newnib;
    new_row  = row;
    mod_n    = '0;
    mod_emit = 1'b1;
    rg_wdata = rg;
    for (int k = 0; k < 8; k++) begin
      mod_pidx[k] = '0;
    end
    for (int k = 0; k < 8; k++) begin
      x      = (bx << 3) | XW'(k);
      inw    = x < wc;
      bitk   = v[7 - k];
      oldnib = row[4*k +: 4];
      newnib = (plane_number == 2'd0) ? {3'b000, bitk} :
               (oldnib | 4'({3'b000, bitk} << plane_number));
      case (depth_mode)
        prd_pkg::DM_MONO: begin
          mod_pidx[k] = {7'd0, bitk};
          mod_n       = mod_n + 4'(inw);
        end
        prd_pkg::DM_PLANAR4: begin
          mod_pidx[k] = {4'd0, newnib};
          if (inw) begin
            new_row[4*k +: 4] = newnib;
          end
          mod_n = mod_n + 4'(inw && last_plane);
        end
        default: ;
      endcase
    end
    case (depth_mode)
      prd_pkg::DM_PLANAR4: mod_emit = last_plane;
      prd_pkg::DM_INDEXED: begin
        mod_pidx[0] = v;
        mod_n       = 4'(b_in);
      end
      prd_pkg::DM_RGB: begin
        mod_emit = last_plane;
        mod_n    = 4'(b_in && plane_number >= 2'd2);
        rg_wdata = (plane_number == 2'd0) ? {v, rg[7:0]} : {rg[15:8], v};
      end
      default: ;
    endcase
    idx_we = (st == S_MOD) && (depth_mode == prd_pkg::DM_PLANAR4) && (bx < XW'(IRD));
    rg_we  = (st == S_MOD) && (depth_mode == prd_pkg::DM_RGB) && b_in &&
             (plane_number < 2'd2);
  end

  assign cmd_ready = st == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      byte_in_line <= '0;
      plane_number <= '0;
      line_number  <= '0;
      finished     <= 1'b0;
      pend_valid   <= 1'b0;
      ob_valid     <= 1'b0;
    end else begin
      if (ob_load) begin
        ob_valid <= 1'b1;
      end else if (ob_valid && pixels.ready) begin
        ob_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.op == prd_pkg::OP_START) begin
              byte_in_line <= '0;
              plane_number <= '0;
              line_number  <= '0;
              finished     <= 1'b0;
            end else if (cmd.op == prd_pkg::OP_BYTE && !finished) begin
              st <= S_RD;
            end
          end
        end
        S_RD: st <= S_MOD;
        S_MOD: st <= S_PAL;
        S_PAL: begin
          if (j == nr) begin
            st <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!(emit && pend_valid && !ob_free)) begin
            if (emit) begin
              pend_valid <= 1'b1;
            end
            // advance the position
            if (line_end) begin
              byte_in_line <= '0;
              if (last_plane) begin
                plane_number <= '0;
                line_number  <= line_number + 16'd1;
                if (img_end) begin
                  finished <= 1'b1;
                end
              end else begin
                plane_number <= plane_number + 2'd1;
              end
            end else begin
              byte_in_line <= byte_in_line + 1'b1;
            end
            st <= (cnt == 6'd1 || finishing) ? S_FLUSH : S_RD;
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            st <= S_IDLE;
          end else if (ob_free) begin
            pend_valid <= 1'b0;
            st         <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // Payload: command, pixel collection, held result, output register
  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        v   <= cmd.data;
        cnt <= cmd.cnt;
      end
      S_MOD: begin
        j    <= '0;
        n    <= mod_n;
        emit <= mod_emit;
        nr   <= (mod_emit && depth_mode != prd_pkg::DM_RGB) ? mod_n : 4'd0;
        pidx <= mod_pidx;
        pix[0] <= {rg, v};
      end
      S_PAL: begin
        if (j != 4'd0) begin
          pix[3'(j - 4'd1)] <= pal_rdata;
        end
        if (j != nr) begin
          j <= j + 4'd1;
        end
      end
      S_EMIT: begin
        if (!(emit && pend_valid && !ob_free)) begin
          cnt <= cnt - 6'd1;
          if (emit) begin
            if (pend_valid) begin
              ob_n    <= pend_n;
              ob_pix  <= pend_pix;
              ob_done <= pend_done;
              ob_last <= 1'b0;
            end
            pend_n    <= n;
            pend_done <= finishing;
            for (int k = 0; k < 8; k++) begin
              pend_pix[k] <= (4'(k) < n) ? pix[k] : 24'd0;
            end
          end
        end
      end
      S_FLUSH: begin
        if (pend_valid && ob_free) begin
          ob_n    <= pend_n;
          ob_pix  <= pend_pix;
          ob_done <= pend_done;
          ob_last <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign pixels.valid       = ob_valid;
  assign pixels.pixel_count = ob_n;
  assign pixels.pix0        = ob_pix[0];
  assign pixels.pix1        = ob_pix[1];
  assign pixels.pix2        = ob_pix[2];
  assign pixels.pix3        = ob_pix[3];
  assign pixels.pix4        = ob_pix[4];
  assign pixels.pix5        = ob_pix[5];
  assign pixels.pix6        = ob_pix[6];
  assign pixels.pix7        = ob_pix[7];
  assign pixels.run_last    = ob_last;
  assign pixels.image_done  = ob_done;

endmodule

>>> hw/rtl/pcx_rle_pixel_decoder_top.sv
// ----------------------------------------------------------------------------
// pcx_rle_pixel_decoder_top
// PCX run-length decoder: compressed file bytes in, groups of RGB pixels out.
// ----------------------------------------------------------------------------
// Channels: "data" carries input items (palette write, file byte, start of a
// new image), "pixels" carries result items of up to eight RGB pixels, and
// "cfg" writes the four registers (depth mode, line bytes, width, height);
// the user must write them only while the block is idle, which the block
// does not enforce. Every channel moves an item on valid && ready. The front
// resolves run counts and queues decode commands; the back walks each
// decoded byte through the line stores and the palette RAM. Throughput: one
// input item a cycle into the queue while it is not full; in the back each
// decoded byte passes the read, modify, palette and emit states, with one
// read of the single palette read port per pixel (up to 8 in mono and
// four-plane modes, 1 in indexed mode, none for 24-bit); a run repeats that
// per copy. Palette writes and starts are handled in the idle state.
// A result leaves once the next result of the same item is ready, or, with
// run_last set, from the flush state after the item's last decoded byte.
// Reset: clears the decode position, the queue and the output register, and
// loads the register defaults. Palette and line stores keep their contents.
// A stalled receiver holds the output register; the back then stops, the
// queue fills and "data" drops ready.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_decoder_top #(
  parameter int MAX_WIDTH      = prd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LINE_BYTES = prd_pkg::DEF_MAX_LINE_BYTES
) (
  input  logic      clk,
  input  logic      rst,
  prd_in_if.sink    data,
  prd_cfg_if.sink   cfg,
  prd_out_if.source pixels
);

  logic          q_full;
  logic          q_push;
  prd_pkg::cmd_t q_cmd;
  logic          cmd_valid;
  logic          cmd_ready;
  prd_pkg::cmd_t cmd;

  // classify items and turn run counts into commands
  prd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .data   (data),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_cmd)
  );

  // decouple the front from the pixel back end
  prd_queue #(.DEPTH(prd_pkg::QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop_valid (cmd_valid),
    .pop_cmd   (cmd),
    .pop       (cmd_ready)
  );

  // decode bytes into pixels
  prd_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_LINE_BYTES (MAX_LINE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .pixels    (pixels)
  );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PCX run-length pixel decoder.
// Loads the palette and walks a short table of directed items. It then runs
// phases of random, mostly well-formed run-length streams under several
// register settings. Every result is checked against a behavioural decoder
// kept in the bench. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int MAXW         = prd_pkg::DEF_MAX_WIDTH;
  localparam int MAXLB        = prd_pkg::DEF_MAX_LINE_BYTES;
  localparam int PAL_FILL     = 64;
  localparam logic [1:0] IN_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  prd_in_if  data ();
  prd_cfg_if cfg ();
  prd_out_if pixels ();

  pcx_rle_pixel_decoder_top dut (
    .clk    (clk),
    .rst    (rst),
    .data   (data),
    .cfg    (cfg),
    .pixels (pixels)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one input item as the sender sees it
  typedef struct {
    logic [1:0] mode;
    logic [7:0] pidx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] fbyte;
  } item_t;

  // one group of pixels
  typedef struct {
    logic [3:0]  cnt;
    logic [23:0] px [8];
    logic        last;
    logic        done;
  } group_t;

  // directed row: item plus an optional typed expectation of its single group
  typedef struct {
    item_t       it;
    bit          typed;
    logic [3:0]  cnt;
    logic [23:0] px0;
    logic        done;
  } row_t;

  group_t pending_groups[$];
  int     fails = 0;
  int     cycles = 0;
  bit     hold_long = 1'b0;
  bit     hold_seen = 1'b0;

  // decoder state held by the bench
  logic [1:0]  depth_r;
  logic [12:0] lbytes_r;
  logic [12:0] width_r;
  logic [15:0] height_r;
  logic [5:0]  run_cnt;
  logic        want_value;
  logic [11:0] byte_pos;
  logic [1:0]  plane;
  logic [15:0] line_no;
  logic        img_done;
  logic [23:0] palette [256];
  logic [3:0]  idx_line [MAXW];
  logic [15:0] rg_line [MAXW];

  function automatic logic [23:0] pal_seed(int i);
    return {i[7:0], ~i[7:0], i[7:0] ^ 8'h5a};
  endfunction

  // in indexed mode keep byte values on palette entries that were loaded
  function automatic logic [7:0] pick_byte(bit literal);
    if (depth_r == prd_pkg::DM_INDEXED) return 8'($urandom_range(0, PAL_FILL - 1));
    return literal ? 8'($urandom_range(0, 8'hBF)) : 8'($urandom);
  endfunction

  task automatic clear_position();
    run_cnt    = '0;
    want_value = 1'b0;
    byte_pos   = '0;
    plane      = '0;
    line_no    = '0;
    img_done   = 1'b0;
  endtask

  // expand one decoded byte at the current position; emit says a group leaves
  task automatic decode_one(input logic [7:0] v, output group_t g, output bit emit);
    int lb, w, np, b, c, x;
    bit last_pl, bitv;
    lb = (lbytes_r == 0) ? 1 : ((lbytes_r > MAXLB) ? MAXLB : int'(lbytes_r));
    w  = (width_r > MAXW) ? MAXW : int'(width_r);
    np = (depth_r == prd_pkg::DM_PLANAR4) ? 4 : ((depth_r == prd_pkg::DM_RGB) ? 3 : 1);
    b  = byte_pos;
    c  = plane;
    last_pl = (c + 1) >= np;
    g.cnt = 0;
    g.last = 1'b0;
    g.done = 1'b0;
    for (int k = 0; k < 8; k++) g.px[k] = '0;
    emit = 1'b1;
    case (depth_r)
      prd_pkg::DM_MONO: begin
        for (int k = 0; k < 8; k++) begin
          x = b * 8 + k;
          if (x < w) begin
            bitv = v[7-k];
            g.px[g.cnt] = palette[bitv];
            g.cnt++;
          end
        end
      end
      prd_pkg::DM_PLANAR4: begin
        for (int k = 0; k < 8; k++) begin
          x = b * 8 + k;
          if (x < w) begin
            bitv = v[7-k];
            if (c == 0) idx_line[x] = {3'b000, bitv};
            else        idx_line[x] = idx_line[x] | (4'(bitv) << c);
            if (last_pl) begin
              g.px[g.cnt] = palette[idx_line[x]];
              g.cnt++;
            end
          end
        end
        emit = last_pl;
      end
      prd_pkg::DM_INDEXED: begin
        if (b < w) begin
          g.px[0] = palette[v];
          g.cnt = 1;
        end
      end
      default: begin
        if (b < w) begin
          if (c == 0)      rg_line[b] = {v, rg_line[b][7:0]};
          else if (c == 1) rg_line[b] = {rg_line[b][15:8], v};
          else begin
            g.px[0] = {rg_line[b], v};
            g.cnt = 1;
          end
        end
        emit = last_pl;
      end
    endcase
    // advance the position
    if (b + 1 >= lb) begin
      byte_pos = '0;
      if (last_pl) begin
        plane = '0;
        if (int'(line_no) + 1 >= int'(height_r)) begin
          img_done = 1'b1;
          g.done = 1'b1;
        end
        line_no = line_no + 16'd1;
      end else begin
        plane = plane + 2'd1;
      end
    end else begin
      byte_pos = byte_pos + 12'd1;
    end
  endtask

  // work out the groups of one accepted item and queue them
  task automatic predict_item(input item_t it, input row_t row);
    group_t g, grp[$];
    bit emit;
    int reps;
    if (it.mode == prd_pkg::IN_PAL) begin
      palette[it.pidx] = {it.red, it.green, it.blue};
      return;
    end
    if (it.mode == prd_pkg::IN_START) begin
      clear_position();
      return;
    end
    if (it.mode != prd_pkg::IN_BYTE || img_done) return;
    if (want_value) begin
      want_value = 1'b0;
      reps = run_cnt;
      run_cnt = '0;
    end else if (it.fbyte >= prd_pkg::RUN_MARK) begin
      want_value = 1'b1;
      run_cnt = 6'(it.fbyte - prd_pkg::RUN_MARK);
      return;
    end else begin
      reps = 1;
    end
    for (int i = 0; i < reps && !img_done; i++) begin
      decode_one(it.fbyte, g, emit);
      if (emit) grp.push_back(g);
    end
    if (grp.size() > 0) grp[grp.size()-1].last = 1'b1;
    // a typed row overrides the decoder with the value read off by hand
    if (row.typed && grp.size() > 0) begin
      grp[0].cnt   = row.cnt;
      grp[0].px[0] = row.px0;
      grp[0].done  = row.done;
    end
    foreach (grp[i]) pending_groups.push_back(grp[i]);
  endtask

  // ---- sender side ---------------------------------------------------------

  // hold the item until accepted; an optional gap lowers valid first
  task automatic send(input item_t it, input row_t row);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ?
          (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
    if (gap > 0) begin
      data.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data.valid     <= 1'b1;
    data.mode      <= it.mode;
    data.pal_index <= it.pidx;
    data.pal_red   <= it.red;
    data.pal_green <= it.green;
    data.pal_blue  <= it.blue;
    data.file_byte <= it.fbyte;
    @(posedge clk);
    while (!data.ready) @(posedge clk);
    predict_item(it, row);
  endtask

  task automatic send_plain(input item_t it);
    row_t none;
    none.typed = 1'b0;
    send(it, none);
  endtask

  function automatic item_t mk(logic [1:0] m, logic [7:0] fb);
    item_t it;
    it.mode  = m;
    it.fbyte = fb;
    it.pidx  = 8'($urandom);
    it.red   = 8'($urandom);
    it.green = 8'($urandom);
    it.blue  = 8'($urandom);
    return it;
  endfunction

  // drop valid, wait for every group to land, then let the back drain the
  // bytes that give no result (earlier planes of a line)
  task automatic settle();
    data.valid <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      prd_pkg::CFG_DEPTH:  depth_r  = val[1:0];
      prd_pkg::CFG_LINE:   lbytes_r = val[12:0];
      prd_pkg::CFG_WIDTH:  width_r  = val[12:0];
      default:             height_r = val;
    endcase
  endtask

  task automatic configure(input logic [1:0] dm, input logic [15:0] lb,
                           input logic [15:0] w, input logic [15:0] h);
    write_reg(prd_pkg::CFG_DEPTH, {14'd0, dm});
    write_reg(prd_pkg::CFG_LINE, lb);
    write_reg(prd_pkg::CFG_WIDTH, w);
    write_reg(prd_pkg::CFG_HEIGHT, h);
  endtask

  // ---- receiver side: check and stall ------------------------------------

  int stall_left = 0;

  always @(posedge clk) begin
    group_t e;
    logic [23:0] got [8];
    if (!rst && pixels.valid && pixels.ready) begin
      got = '{pixels.pix0, pixels.pix1, pixels.pix2, pixels.pix3,
              pixels.pix4, pixels.pix5, pixels.pix6, pixels.pix7};
      if (pending_groups.size() == 0) begin
        $error("unexpected pixel group, count %0d", pixels.pixel_count);
        fails++;
      end else begin
        e = pending_groups.pop_front();
        if (pixels.pixel_count !== e.cnt) begin
          $error("pixel_count: expected %0d, got %0d", e.cnt, pixels.pixel_count);
          fails++;
        end
        for (int k = 0; k < 8; k++)
          if (got[k] !== e.px[k]) begin
            $error("pix%0d: expected %06h, got %06h", k, e.px[k], got[k]);
            fails++;
          end
        if (pixels.run_last !== e.last) begin
          $error("run_last: expected %0b, got %0b", e.last, pixels.run_last);
          fails++;
        end
        if (pixels.image_done !== e.done) begin
          $error("image_done: expected %0b, got %0b", e.done, pixels.image_done);
          fails++;
        end
      end
    end
    // pick the next stall: a long hold on request, else short random gaps
    if (hold_long && !hold_seen) begin
      hold_seen  <= 1'b1;
      stall_left <= 400;
      pixels.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      pixels.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= ($urandom_range(0, 12) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
      pixels.ready <= 1'b0;
    end else begin
      pixels.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---- stimulus ------------------------------------------------------------

  row_t table_rows[$];

  task automatic add_row(logic [1:0] m, logic [7:0] fb, bit typed,
                         logic [3:0] cnt, logic [23:0] px0, logic done);
    row_t r;
    r.it    = mk(m, fb);
    r.typed = typed;
    r.cnt   = cnt;
    r.px0   = px0;
    r.done  = done;
    table_rows.push_back(r);
  endtask

  // one random phase of mostly well-formed run-length data
  task automatic random_phase(input int n_items);
    item_t it;
    int pick;
    send_plain(mk(prd_pkg::IN_START, 8'h00));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_plain(mk(prd_pkg::IN_BYTE, pick_byte(1'b1)));
      end else if (pick < 85) begin
        // run pair: mostly short counts, sometimes any count up to the longest
        it = mk(prd_pkg::IN_BYTE, ($urandom_range(0, 7) == 0) ?
                8'($urandom_range(8'hC0, 8'hFF)) : 8'($urandom_range(8'hC0, 8'hC4)));
        send_plain(it);
        send_plain(mk(prd_pkg::IN_BYTE, pick_byte(1'b0)));
      end else if (pick < 91) begin
        send_plain(mk(prd_pkg::IN_PAL, 8'h00));
      end else if (pick < 95) begin
        send_plain(mk(IN_UNUSED, 8'($urandom)));
      end else begin
        send_plain(mk(prd_pkg::IN_START, 8'($urandom)));
      end
    end
    settle();
  endtask

  initial begin
    item_t it;
    data.valid     = 1'b0;
    data.mode      = prd_pkg::IN_START;
    data.pal_index = '0;
    data.pal_red   = '0;
    data.pal_green = '0;
    data.pal_blue  = '0;
    data.file_byte = '0;
    cfg.valid      = 1'b0;
    cfg.index      = prd_pkg::CFG_DEPTH;
    cfg.data       = '0;
    depth_r  = prd_pkg::DM_INDEXED;
    lbytes_r = 13'd1;
    width_r  = 13'd1;
    height_r = 16'd1;
    clear_position();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // load the low palette entries plus the two top ones the table reads;
    // indexed byte values stay on loaded entries
    for (int i = 0; i < PAL_FILL + 2; i++) begin
      it = mk(prd_pkg::IN_PAL, 8'h00);
      it.pidx = (i == PAL_FILL) ? 8'hBF : ((i > PAL_FILL) ? 8'hFF : 8'(i));
      {it.red, it.green, it.blue} = pal_seed(int'(it.pidx));
      send_plain(it);
    end
    settle();

    // directed table under the reset registers: indexed, one byte, one line
    add_row(prd_pkg::IN_BYTE,  8'h05, 1, 4'd1, pal_seed(5), 1'b1);  // literal ends image
    add_row(prd_pkg::IN_BYTE,  8'h09, 0, 0, 0, 0);                  // ignored after image
    add_row(prd_pkg::IN_START, 8'h00, 0, 0, 0, 0);
    add_row(prd_pkg::IN_BYTE,  8'hC0, 0, 0, 0, 0);                  // zero-length run
    add_row(prd_pkg::IN_BYTE,  8'h33, 0, 0, 0, 0);
    add_row(IN_UNUSED,         8'hFF, 0, 0, 0, 0);                  // unused mode value
    add_row(prd_pkg::IN_BYTE,  8'hC3, 0, 0, 0, 0);                  // run cut short
    add_row(prd_pkg::IN_BYTE,  8'h00, 1, 4'd1, pal_seed(0), 1'b1);
    add_row(prd_pkg::IN_START, 8'h00, 0, 0, 0, 0);
    add_row(prd_pkg::IN_BYTE,  8'hC1, 0, 0, 0, 0);                  // run of one, top value
    add_row(prd_pkg::IN_BYTE,  8'hFF, 1, 4'd1, pal_seed(255), 1'b1);
    add_row(prd_pkg::IN_START, 8'h00, 0, 0, 0, 0);
    add_row(prd_pkg::IN_BYTE,  8'hBF, 1, 4'd1, pal_seed(8'hBF), 1'b1); // largest literal
    add_row(prd_pkg::IN_START, 8'h00, 0, 0, 0, 0);
    add_row(prd_pkg::IN_BYTE,  8'hFF, 0, 0, 0, 0);                  // longest run count
    add_row(prd_pkg::IN_BYTE,  8'h3C, 0, 0, 0, 0);
    foreach (table_rows[i]) send(table_rows[i].it, table_rows[i]);
    settle();

    // extremes: out-of-range line length and width, height zero; long hold
    // on the receiver while the sender keeps offering run pairs
    configure(prd_pkg::DM_INDEXED, 16'h1FFF, 16'h1FFF, 16'h0000);
    send_plain(mk(prd_pkg::IN_START, 8'h00));
    hold_long = 1'b1;
    for (int i = 0; i < 66; i++) begin
      send_plain(mk(prd_pkg::IN_BYTE, 8'hFF));
      send_plain(mk(prd_pkg::IN_BYTE, pick_byte(1'b0)));
    end
    settle();

    // settings per phase: fixed corners first, then random ones
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: configure(prd_pkg::DM_MONO, 16'd0, 16'd0, 16'd1);     // line 0 acts as 1, width 0
        1: configure(prd_pkg::DM_PLANAR4, 16'd2, 16'd13, 16'd3);
        2: configure(prd_pkg::DM_RGB, 16'd3, 16'd3, 16'd2);
        3: configure(prd_pkg::DM_MONO, 16'd4096, 16'd4096, 16'hFFFF);
        default: configure(2'($urandom), 16'($urandom_range(1, 6)),
                           16'($urandom_range(0, 50)), 16'($urandom_range(1, 4)));
      endcase
      random_phase(8);
    end

    data.valid <= 1'b0;
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
